[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the scheduler modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/ers_pkg.sv]
// ----------------------------------------------------------------------------
// ers_pkg
// Types, codes and scan helpers shared by the elevator request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ers_pkg;

    localparam int FLOORS  = 16;
    localparam int FIDX_W  = $clog2(FLOORS);
    localparam int FLOOR_W = 4;

    typedef enum logic [1:0] {
        ACT_HALL       = 2'd0,
        ACT_CABIN      = 2'd1,
        ACT_ARRIVE     = 2'd2,
        ACT_BOARD_DONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DN   = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        MODE_FREE     = 2'd0,
        MODE_MOVING   = 2'd1,
        MODE_BOARDING = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_UP    = 3'd1,
        CMD_DOWN  = 3'd2,
        CMD_BOARD = 3'd3,
        CMD_IDLE  = 3'd4
    } t_command;

    typedef struct packed {
        logic [1:0]         action;
        logic [FLOOR_W-1:0] floor;
        logic               direction;
    } t_in;

    typedef struct packed {
        logic [2:0]         command;
        logic [FLOOR_W-1:0] current_floor;
        logic [FLOOR_W-1:0] target_floor;
        logic               target_valid;
    } t_out;

    typedef struct packed {
        logic upd;
        logic load;
        logic sel;
    } t_dp_cmd;

    typedef struct packed {
        logic need_sel;
    } t_dp_st;

    typedef struct packed {
        logic              found;
        logic [FIDX_W-1:0] idx;
    } t_pe;

    function automatic t_pe pe_lo(input logic [FLOORS-1:0] v);
        t_pe r;
        r = '0;
        for (int i = FLOORS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = FIDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic t_pe pe_hi(input logic [FLOORS-1:0] v);
        t_pe r;
        r = '0;
        for (int i = 0; i < FLOORS; i++) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = FIDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [FLOORS-1:0] mask_gt(input logic [FIDX_W-1:0] c);
        logic [FLOORS-1:0] m;
        for (int i = 0; i < FLOORS; i++) begin
            m[i] = (i > int'(c));
        end
        return m;
    endfunction

    function automatic logic [FLOORS-1:0] mask_lt(input logic [FIDX_W-1:0] c);
        logic [FLOORS-1:0] m;
        for (int i = 0; i < FLOORS; i++) begin
            m[i] = (i < int'(c));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[hdl/elevator_request_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// elevator_request_scheduler_unit
// Scan-style elevator dispatch: stores hall and cabin calls per floor and
// selects the next target floor and a move, board or idle command.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat. An accepted beat updates
// the request store or cabin floor in its acceptance cycle; the target scan
// (a set of priority encoders over the floor request vectors) then runs in
// state S_SEL and loads the result register once the output side can take
// it. No new beat is taken until that load, so one item is in flight at a
// time. A new beat is taken while an earlier result still waits at the
// output; the scan cycle stalls only until that result is taken.
`default_nettype none

module elevator_request_scheduler_unit
    import ers_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_dp_cmd dp_cmd;
    t_dp_st  dp_st;

    ers_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_st        (dp_st),
        .o_cmd       (dp_cmd)
    );

    ers_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cmd   (dp_cmd),
        .o_st    (dp_st),
        .o_out   (o_out_data)
    );

endmodule

`default_nettype wire

[hdl/ers_ctl.sv]
// ----------------------------------------------------------------------------
// ers_ctl
// Sequencer: takes one beat, runs the selection step, holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ers_ctl
    import ers_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_st  i_st,
    output t_dp_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_SEL
    } t_state;

    t_state r_state;
    logic   r_sel;
    logic   r_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.upd  = accept;
        o_cmd.load = (r_state == S_SEL) && (!r_out_valid || i_out_ready);
        o_cmd.sel  = r_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sel   <= i_st.need_sel;
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (o_cmd.load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_one_item_in_flight, i_clk, i_rst_n, accept, !o_in_ready && !o_cmd.upd)
    `ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, o_cmd.load, o_out_valid && o_in_ready)
    `ASSERT_SAME(a_no_load_on_accept, i_clk, i_rst_n, o_cmd.upd, !o_cmd.load)

endmodule

`default_nettype wire

[hdl/ers_dp.sv]
// ----------------------------------------------------------------------------
// ers_dp
// Request store, cabin state, target scan by priority encoders, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ers_dp
    import ers_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_in     i_in,
    input  wire t_dp_cmd i_cmd,
    output t_dp_st       o_st,
    output t_out         o_out
);

    logic [FLOORS-1:0] r_hall_up;
    logic [FLOORS-1:0] r_hall_dn;
    logic [FLOORS-1:0] r_cab;
    logic [FIDX_W-1:0] r_cur;
    t_dir              r_dir;
    t_mode             r_mode;
    t_out              r_out;

    logic [FLOORS-1:0] any_v;
    logic [FLOORS-1:0] up_v;
    logic [FLOORS-1:0] dn_v;
    logic [FLOORS-1:0] m_gt;
    logic [FLOORS-1:0] m_lt;
    logic              in_range;
    logic [FIDX_W-1:0] in_idx;

    t_pe               pa;
    t_pe               pb;
    t_pe               p1;
    t_pe               p2;
    t_pe               p3;
    logic              sel_found;
    logic [FIDX_W-1:0] sel_idx;

    t_out              n_out;
    t_dir              n_dir;
    t_mode             n_mode;
    logic              n_board;

    assign any_v    = r_cab | r_hall_up | r_hall_dn;
    assign up_v     = r_cab | r_hall_up;
    assign dn_v     = r_cab | r_hall_dn;
    assign m_gt     = mask_gt(r_cur);
    assign m_lt     = mask_lt(r_cur);
    assign in_range = (int'(i_in.floor) < FLOORS);
    assign in_idx   = i_in.floor[FIDX_W-1:0];

    assign o_st.need_sel = (i_in.action == ACT_BOARD_DONE)
                         || (in_range && ((i_in.action == ACT_ARRIVE) || (r_mode == MODE_FREE)));

    always_comb begin
        pa        = '0;
        pb        = '0;
        p1        = '0;
        p2        = '0;
        p3        = '0;
        sel_found = 1'b0;
        sel_idx   = '0;
        case (r_dir)
            DIR_UP: begin
                p1 = pe_lo(up_v & m_gt);
                p2 = pe_hi(any_v & ~m_lt);
                p3 = pe_hi(any_v & m_lt);
                if (up_v[r_cur]) begin
                    sel_found = 1'b1;
                    sel_idx   = r_cur;
                end else if (p1.found) begin
                    sel_found = 1'b1;
                    sel_idx   = p1.idx;
                end else if (p2.found) begin
                    sel_found = 1'b1;
                    sel_idx   = p2.idx;
                end else if (p3.found) begin
                    sel_found = 1'b1;
                    sel_idx   = p3.idx;
                end
            end
            DIR_DN: begin
                p1 = pe_hi(dn_v & m_lt);
                p2 = pe_lo(any_v & ~m_gt);
                p3 = pe_lo(any_v & m_gt);
                if (dn_v[r_cur]) begin
                    sel_found = 1'b1;
                    sel_idx   = r_cur;
                end else if (p1.found) begin
                    sel_found = 1'b1;
                    sel_idx   = p1.idx;
                end else if (p2.found) begin
                    sel_found = 1'b1;
                    sel_idx   = p2.idx;
                end else if (p3.found) begin
                    sel_found = 1'b1;
                    sel_idx   = p3.idx;
                end
            end
            default: begin
                pb = pe_hi(any_v & ~m_gt);
                pa = pe_lo(any_v & m_gt);
                if (pb.found && (!pa.found || ((r_cur - pb.idx) <= (pa.idx - r_cur)))) begin
                    sel_found = 1'b1;
                    sel_idx   = pb.idx;
                end else if (pa.found) begin
                    sel_found = 1'b1;
                    sel_idx   = pa.idx;
                end
            end
        endcase
    end

    always_comb begin
        n_out               = '0;
        n_out.command       = CMD_NONE;
        n_out.current_floor = FLOOR_W'(r_cur);
        n_dir               = r_dir;
        n_mode              = r_mode;
        n_board             = 1'b0;
        if (i_cmd.sel) begin
            if (!sel_found) begin
                n_out.command = CMD_IDLE;
                n_dir         = DIR_HOLD;
                n_mode        = MODE_FREE;
            end else begin
                n_out.target_floor = FLOOR_W'(sel_idx);
                n_out.target_valid = 1'b1;
                if (sel_idx == r_cur) begin
                    n_out.command = CMD_BOARD;
                    n_mode        = MODE_BOARDING;
                    n_board       = 1'b1;
                end else if (sel_idx > r_cur) begin
                    n_out.command = CMD_UP;
                    n_dir         = DIR_UP;
                    n_mode        = MODE_MOVING;
                end else begin
                    n_out.command = CMD_DOWN;
                    n_dir         = DIR_DN;
                    n_mode        = MODE_MOVING;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hall_up <= '0;
            r_hall_dn <= '0;
            r_cab     <= '0;
            r_cur     <= '0;
            r_dir     <= DIR_HOLD;
            r_mode    <= MODE_FREE;
        end else begin
            if (i_cmd.upd && in_range) begin
                case (i_in.action)
                    ACT_HALL: begin
                        if (i_in.direction) begin
                            r_hall_dn[in_idx] <= 1'b1;
                        end else begin
                            r_hall_up[in_idx] <= 1'b1;
                        end
                    end
                    ACT_CABIN: begin
                        r_cab[in_idx] <= 1'b1;
                    end
                    ACT_ARRIVE: begin
                        r_cur <= in_idx;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load && i_cmd.sel) begin
                r_dir  <= n_dir;
                r_mode <= n_mode;
                if (n_board) begin
                    r_hall_up[r_cur] <= 1'b0;
                    r_hall_dn[r_cur] <= 1'b0;
                    r_cab[r_cur]     <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

    `ASSERT_NEXT(a_board_clears_floor, i_clk, i_rst_n, i_cmd.load && n_board, !any_v[r_cur])
    `ASSERT_NEXT(a_idle_only_when_empty, i_clk, i_rst_n, i_cmd.load && i_cmd.sel && !sel_found, any_v == '0)
    `ASSERT_NEXT(a_no_select_no_target, i_clk, i_rst_n, i_cmd.load && !i_cmd.sel, o_out.command == CMD_NONE && !o_out.target_valid)

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator request scheduler testbench
// Sends hall calls, cabin calls, arrivals and boarding-finished beats through
// the input channel and checks every result beat against a dispatch predictor
// that tracks the request store, cabin floor, travel direction and mode.
// ----------------------------------------------------------------------------

module testbench;
    import ers_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          TOP_FLOOR    = FLOORS - 1;
    localparam int          RANDOM_ITEMS = 600;
    localparam logic [1:0]  HALL_UP_BIT  = 2'b01;
    localparam logic [1:0]  HALL_DN_BIT  = 2'b10;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    logic [1:0]         hall_calls [FLOORS];
    bit                 cabin_calls [FLOORS];
    logic [FLOOR_W-1:0] car_floor;
    t_dir               car_dir;
    t_mode              car_mode;

    t_out pending_responses [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   burst_left     = 0;
    int   stall_style    = 0;
    int   stall_left     = 0;

    elevator_request_scheduler_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit floor_requested(input int f);
        return cabin_calls[f] || (hall_calls[f] != 2'b00);
    endfunction

    function automatic bit floor_on_the_way(input int f, input t_dir d);
        logic [1:0] hall_bit;
        hall_bit = (d == DIR_UP) ? HALL_UP_BIT : HALL_DN_BIT;
        return cabin_calls[f] || ((hall_calls[f] & hall_bit) != 2'b00);
    endfunction

    function automatic int choose_target_floor();
        int cur;
        int step;
        int best;
        int span;
        int delta;
        int f;
        cur  = int'(car_floor);
        best = -1;
        if (car_dir == DIR_UP || car_dir == DIR_DN) begin
            step = (car_dir == DIR_UP) ? 1 : -1;
            if (floor_on_the_way(cur, car_dir)) return cur;
            for (f = cur + step; f >= 0 && f < FLOORS; f += step)
                if (floor_on_the_way(f, car_dir)) return f;
            for (f = cur; f >= 0 && f < FLOORS; f += step)
                if (floor_requested(f)) best = f;
            if (best >= 0) return best;
            for (f = cur - step; f >= 0 && f < FLOORS; f -= step)
                if (floor_requested(f)) return f;
            return -1;
        end
        span = FLOORS + 1;
        for (f = 0; f < FLOORS; f++) begin
            if (floor_requested(f)) begin
                delta = (f > cur) ? f - cur : cur - f;
                if (delta < span) begin
                    span = delta;
                    best = f;
                end
            end
        end
        return best;
    endfunction

    function automatic void dispatch_car(inout t_out res);
        int target;
        target = choose_target_floor();
        if (target < 0) begin
            car_dir     = DIR_HOLD;
            car_mode    = MODE_FREE;
            res.command = CMD_IDLE;
            return;
        end
        res.target_floor = FLOOR_W'(target);
        res.target_valid = 1'b1;
        if (target == int'(car_floor)) begin
            car_mode               = MODE_BOARDING;
            hall_calls[car_floor]  = 2'b00;
            cabin_calls[car_floor] = 1'b0;
            res.command            = CMD_BOARD;
        end else if (target > int'(car_floor)) begin
            car_dir     = DIR_UP;
            car_mode    = MODE_MOVING;
            res.command = CMD_UP;
        end else begin
            car_dir     = DIR_DN;
            car_mode    = MODE_MOVING;
            res.command = CMD_DOWN;
        end
    endfunction

    function automatic t_out predict_response(input t_in item);
        t_out res;
        res = '0;
        if (item.action == ACT_BOARD_DONE) begin
            dispatch_car(res);
        end else if (int'(item.floor) < FLOORS) begin
            case (item.action)
                ACT_HALL: begin
                    hall_calls[item.floor] |= item.direction ? HALL_DN_BIT : HALL_UP_BIT;
                    if (car_mode == MODE_FREE) dispatch_car(res);
                end
                ACT_CABIN: begin
                    cabin_calls[item.floor] = 1'b1;
                    if (car_mode == MODE_FREE) dispatch_car(res);
                end
                default: begin
                    car_floor = item.floor;
                    dispatch_car(res);
                end
            endcase
        end
        res.current_floor = car_floor;
        return res;
    endfunction

    function automatic t_in make_item(input t_action act, input int f, input bit dn);
        t_in item;
        item.action    = act;
        item.floor     = FLOOR_W'(f);
        item.direction = dn;
        return item;
    endfunction

    task automatic send_item(input t_in item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pending_responses.push_back(predict_response(item));
    endtask

    task automatic check_field(input string label, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, o_out_data);
                mismatch_count++;
            end else begin
                want = pending_responses.pop_front();
                check_field("command", want.command, o_out_data.command);
                check_field("current_floor", want.current_floor, o_out_data.current_floor);
                check_field("target_floor", want.target_floor, o_out_data.target_floor);
                check_field("target_valid", want.target_valid, o_out_data.target_valid);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(20, 80);
            end
            stall_left--;
            case (stall_style)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (cycle_count % 16 == 0);
            endcase
        end
    end

    task automatic test_idle_on_empty();
        send_item(make_item(ACT_BOARD_DONE, 0, 1'b0));
        send_item(make_item(ACT_ARRIVE, 0, 1'b1));
    endtask

    task automatic test_scan_travel();
        send_item(make_item(ACT_HALL, TOP_FLOOR, 1'b1));
        send_item(make_item(ACT_CABIN, 0, 1'b0));
        send_item(make_item(ACT_HALL, 7, 1'b0));
        send_item(make_item(ACT_ARRIVE, 7, 1'b0));
        send_item(make_item(ACT_BOARD_DONE, 7, 1'b0));
        send_item(make_item(ACT_ARRIVE, TOP_FLOOR, 1'b0));
        send_item(make_item(ACT_BOARD_DONE, TOP_FLOOR, 1'b1));
        send_item(make_item(ACT_HALL, 5, 1'b0));
        send_item(make_item(ACT_HALL, 5, 1'b1));
        send_item(make_item(ACT_HALL, 5, 1'b0));
        send_item(make_item(ACT_ARRIVE, 5, 1'b1));
        send_item(make_item(ACT_BOARD_DONE, 5, 1'b0));
        send_item(make_item(ACT_ARRIVE, 0, 1'b0));
        send_item(make_item(ACT_BOARD_DONE, 0, 1'b0));
    endtask

    task automatic test_standing_tie();
        send_item(make_item(ACT_ARRIVE, 8, 1'b0));
        send_item(make_item(ACT_CABIN, 8, 1'b1));
        send_item(make_item(ACT_HALL, 10, 1'b0));
        send_item(make_item(ACT_HALL, 6, 1'b1));
        send_item(make_item(ACT_BOARD_DONE, 0, 1'b0));
        send_item(make_item(ACT_ARRIVE, 6, 1'b0));
        send_item(make_item(ACT_ARRIVE, 3, 1'b1));
        send_item(make_item(ACT_BOARD_DONE, 3, 1'b0));
    endtask

    task automatic test_random_traffic(input int count);
        t_in item;
        int  pick;
        int  f;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                item = t_in'($bits(t_in)'($urandom));
            end else if (pick < 35 || car_mode == MODE_FREE) begin
                f = ($urandom_range(0, 3) == 0) ? int'(car_floor) : $urandom_range(0, TOP_FLOOR);
                item = make_item(t_action'($urandom_range(0, 1)), f,
                                 1'($urandom_range(0, 1)));
            end else if (car_mode == MODE_BOARDING) begin
                item = make_item(ACT_BOARD_DONE, $urandom_range(0, TOP_FLOOR),
                                 1'($urandom_range(0, 1)));
            end else begin
                f = int'(car_floor);
                if (car_dir == DIR_UP && f < TOP_FLOOR)
                    f = ($urandom_range(0, 3) != 0) ? f + 1 : $urandom_range(f + 1, TOP_FLOOR);
                else if (car_dir == DIR_DN && f > 0)
                    f = ($urandom_range(0, 3) != 0) ? f - 1 : $urandom_range(0, f - 1);
                else
                    f = $urandom_range(0, TOP_FLOOR);
                item = make_item(ACT_ARRIVE, f, 1'($urandom_range(0, 1)));
            end
            send_item(item);
        end
    endtask

    initial begin
        for (int f = 0; f < FLOORS; f++) begin
            hall_calls[f]  = 2'b00;
            cabin_calls[f] = 1'b0;
        end
        car_floor = '0;
        car_dir   = DIR_HOLD;
        car_mode  = MODE_FREE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_on_empty();
        test_scan_travel();
        test_standing_tie();
        test_random_traffic(RANDOM_ITEMS);
        i_in_valid <= 1'b0;

        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[elevator_request_scheduler_unit.f]
+incdir+hdl
hdl/ers_pkg.sv
hdl/ers_ctl.sv
hdl/ers_dp.sv
hdl/elevator_request_scheduler_unit.sv
tb/testbench.sv
